/* rtl/core/fen_pkg.sv */
package fen_pkg;

  // Element store size and the widths that follow from it.
  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);

  // Field widths of the request and result items.
  localparam int IDX_W   = 11;
  localparam int VALUE_W = 61;
  localparam int SUM_W   = 64;

  // Stream bus widths: index, index and value packed, padded to whole bytes.
  localparam int REQ_BITS   = 2 * IDX_W + VALUE_W;
  localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_USED_ENTRIES = 0;

  // Operation codes carried on the request selector.
  localparam logic FUNC_SET = 1'b0;
  localparam logic FUNC_SUM = 1'b1;

  typedef struct packed {
    logic              func;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  last_index;
    logic [VALUE_W-1:0] new_value;
  } fen_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] range_sum;
    logic             bad_range;
  } fen_res_t;

endpackage

/* rtl/core/fen_ram.sv */
module fen_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/fen_engine.sv */
module fen_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fen_pkg::fen_req_t             req,
  input  logic [fen_pkg::IDX_W-1:0]     n_used,
  output logic                          res_valid,
  input  logic                          res_ready,
  output fen_pkg::fen_res_t             res
);

  localparam int AW = fen_pkg::ADDR_W;
  localparam int IW = fen_pkg::IDX_W;
  localparam int SW = fen_pkg::SUM_W;
  localparam int VW = fen_pkg::VALUE_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(fen_pkg::MAX_ENTRIES - 1);
  localparam logic [IW-1:0] MAX_IDX   = IW'(fen_pkg::MAX_ENTRIES);

  typedef enum logic [6:0] {
    ST_CLEAR     = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_SET_DELTA = 7'b0000100,
    ST_UPD       = 7'b0001000,
    ST_WALK_A    = 7'b0010000,
    ST_WALK_B    = 7'b0100000,
    ST_RESULT    = 7'b1000000
  } state_t;

  state_t        state;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] pos;
  logic [IW-1:0] first_q;
  logic [SW-1:0] value_q;
  logic [SW-1:0] delta;
  logic [SW-1:0] acc;
  logic          bad;

  logic          tree_we, elem_we;
  logic [AW-1:0] tree_waddr, tree_raddr, elem_waddr, elem_raddr;
  logic [SW-1:0] tree_wdata, tree_rdata, elem_wdata, elem_rdata;

  logic [IW-1:0] n_eff;
  logic [IW-1:0] first_m1, last_m1, first_m2;
  logic          set_ok, sum_ok;
  logic [SW-1:0] value_ext;
  logic [AW:0]   upd_next;
  logic          upd_over;
  logic [AW-1:0] walk_and, walk_next;
  logic          walk_end;

  // Tree of partial sums and the plain element values.
  fen_ram #(.WIDTH(SW), .DEPTH(fen_pkg::MAX_ENTRIES)) u_tree (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (tree_raddr),
    .rdata (tree_rdata)
  );

  fen_ram #(.WIDTH(SW), .DEPTH(fen_pkg::MAX_ENTRIES)) u_elem (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  // Request checks against the effective size.
  assign n_eff     = (n_used > MAX_IDX) ? MAX_IDX : n_used;
  assign first_m1  = req.first_index - IW'(1);
  assign last_m1   = req.last_index - IW'(1);
  assign first_m2  = first_q - IW'(2);
  assign set_ok    = (req.first_index != '0) && (req.first_index <= n_eff);
  assign sum_ok    = (req.first_index != '0) && (req.first_index <= req.last_index) &&
                     (req.last_index <= n_eff);
  assign value_ext = {{(SW-VW){req.new_value[VW-1]}}, req.new_value};

  // Update chain goes up through pos | (pos + 1); prefix walk goes down.
  assign upd_next  = {1'b0, pos} | ({1'b0, pos} + (AW+1)'(1));
  assign upd_over  = upd_next >= (AW+1)'(fen_pkg::MAX_ENTRIES);
  assign walk_and  = pos & (pos + AW'(1));
  assign walk_end  = (walk_and == '0);
  assign walk_next = walk_and - AW'(1);

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_RESULT);
  assign res.range_sum = acc;
  assign res.bad_range = bad;

  // Memory port steering for each phase.
  always_comb begin
    tree_we    = 1'b0;
    tree_waddr = pos;
    tree_wdata = '0;
    tree_raddr = pos;
    elem_we    = 1'b0;
    elem_waddr = pos;
    elem_wdata = '0;
    elem_raddr = pos;
    unique case (state)
      ST_CLEAR: begin
        tree_we    = 1'b1;
        tree_waddr = clr_addr;
        elem_we    = 1'b1;
        elem_waddr = clr_addr;
      end
      ST_IDLE: begin
        tree_raddr = last_m1[AW-1:0];
        elem_raddr = first_m1[AW-1:0];
      end
      ST_SET_DELTA: begin
        elem_we    = 1'b1;
        elem_wdata = value_q;
      end
      ST_UPD: begin
        tree_we    = 1'b1;
        tree_wdata = tree_rdata + delta;
        tree_raddr = upd_next[AW-1:0];
      end
      ST_WALK_A: begin
        tree_raddr = walk_end ? first_m2[AW-1:0] : walk_next;
      end
      ST_WALK_B: begin
        tree_raddr = walk_next;
      end
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer: one chain node per cycle, each read issued in the cycle before its data is used.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            value_q <= value_ext;
            first_q <= req.first_index;
            acc     <= '0;
            if (req.func == fen_pkg::FUNC_SET) begin
              if (set_ok) begin
                pos   <= first_m1[AW-1:0];
                state <= ST_SET_DELTA;
              end
            end else if (sum_ok) begin
              pos   <= last_m1[AW-1:0];
              bad   <= 1'b0;
              state <= ST_WALK_A;
            end else begin
              bad   <= 1'b1;
              state <= ST_RESULT;
            end
          end
        end
        ST_SET_DELTA: begin
          delta <= value_q - elem_rdata;
          state <= ST_UPD;
        end
        ST_UPD: begin
          pos <= upd_next[AW-1:0];
          if (upd_over) begin
            state <= ST_IDLE;
          end
        end
        ST_WALK_A: begin
          acc <= acc + tree_rdata;
          if (!walk_end) begin
            pos <= walk_next;
          end else if (first_q == IW'(1)) begin
            state <= ST_RESULT;
          end else begin
            pos   <= first_m2[AW-1:0];
            state <= ST_WALK_B;
          end
        end
        ST_WALK_B: begin
          acc <= acc - tree_rdata;
          if (walk_end) begin
            state <= ST_RESULT;
          end else begin
            pos <= walk_next;
          end
        end
        ST_RESULT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The clearing sweep ends in idle after its last entry.
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) && (clr_addr == LAST_ADDR) |=> (state == ST_IDLE))
    else $error("clearing sweep did not finish into idle");

  // The update chain climbs strictly.
  a_upd_climbs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) && !upd_over |=> (state == ST_UPD) && (pos > $past(pos)))
    else $error("update chain did not climb");

  // The prefix walk descends strictly.
  a_walk_descends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK_A || state == ST_WALK_B) && !walk_end |=> (pos < $past(pos)))
    else $error("prefix walk did not descend");

  // Element writes happen only while clearing or storing a set value.
  a_elem_write: assert property (@(posedge clk) disable iff (rst)
    elem_we |-> (state == ST_CLEAR || state == ST_SET_DELTA))
    else $error("element store written outside a set");

endmodule

/* rtl/core/fenwick_range_sum.sv */
// Range-sum store over 1024 signed 64-bit elements, kept as a binary
// indexed tree in on-chip memory.
// Requests come in on the s_ group: s_tuser selects set (0) or range sum (1).
// A set stores new_value at first_index and emits nothing; an index outside
// 1..used_entries is ignored. A sum returns one result on the m_ group with
// the wrapped sum from first_index to last_index, or bad_range set and a
// zero sum when the bounds are rejected.
// One request is in work at a time. A set visits each node on its update
// chain (up to 11), a sum each node on its two prefix walks (up to 10 each)
// before it hands off the result; each chain node costs one access of the
// tree memory's read port.
// The finished result sits in an output register, so the next request is
// taken while m_tready is low; only a second result waits behind it.
// After reset the block clears both memories, one entry per cycle, over all
// 1024 entries with s_tready low; used_entries is writable throughout and
// resets to 1024.
module fenwick_range_sum (
  input  logic                             clk,
  input  logic                             rst,
  // APB configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fen_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [fen_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [fen_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  // Request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // first_index [10:0], last_index [21:11], new_value [82:22], zero pad
  input  logic [fen_pkg::REQ_DATA_W-1:0]   s_tdata,
  // func [0]
  input  logic                             s_tuser,
  // Result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // range_sum [63:0]
  output logic [fen_pkg::SUM_W-1:0]        m_tdata,
  // bad_range [0]
  output logic                             m_tuser
);

  localparam int IW = fen_pkg::IDX_W;
  localparam int VW = fen_pkg::VALUE_W;

  logic [IW-1:0]     used_entries;
  logic              reg_sel;
  fen_pkg::fen_req_t req;
  fen_pkg::fen_res_t res;
  logic              res_valid;
  logic              res_ready;

  // Register decode: the single register is selected by paddr[2] low, at byte addresses 0 to 3.
  assign reg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? fen_pkg::CFG_DATA_W'(used_entries) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_entries <= IW'(1024);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      used_entries <= pwdata[IW-1:0];
    end
  end

  // Unpack the request stream.
  assign req.func        = s_tuser;
  assign req.first_index = s_tdata[IW-1:0];
  assign req.last_index  = s_tdata[2*IW-1:IW];
  assign req.new_value   = s_tdata[2*IW+VW-1:2*IW];

  fen_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req       (req),
    .n_used    (used_entries),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register decouples the engine from a stalled receiver.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= res.range_sum;
      m_tuser <= res.bad_range;
    end
  end

endmodule
